FILE: sv/swdc_pkg.sv
// Shared constants and small types for the sliding-window distinct counter.
// No dependencies; every other file of the block but swdc_fifo imports this package.
package swdc_pkg;

	// Fixed field widths
	localparam int VALUE_W = 10;
	localparam int WS_W    = 9;
	localparam int CNT_W   = 9;

	// Default sizing of the value table and of the window ring
	localparam int DEF_NUM_VALUES = 1024;
	localparam int DEF_MAX_WINDOW = 256;

	// Queue depths (powers of two)
	localparam int CMDQ_DEPTH = 4;
	localparam int RESQ_DEPTH = 2;

	// Configuration write as seen by the front and the back
	typedef struct packed {
		logic              we;
		logic [WS_W-1:0]   data;
	} swdc_cfg_t;

	// Status from the back part to the front part
	typedef struct packed {
		logic clearing;
	} swdc_stat_t;

endpackage

FILE: sv/swdc_fifo.sv
// Small flop-based first-in first-out queue with synchronous flush.
// Depends on nothing; used between front and back and for results.
module swdc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             flush,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W:0]   cnt_q;
	logic             do_push;
	logic             do_pop;

	// Derive flags and the head entry
	assign full    = (cnt_q == (PTR_W+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rdata   = mem_q[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else if (flush) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PTR_W'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PTR_W'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Hold the stored requests
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

FILE: sv/swdc_front.sv
// Front part: accepts values, keeps the window ring, fill and position,
// and issues update and drain requests. Depends on swdc_pkg.
module swdc_front import swdc_pkg::*; #(
	parameter int NUM_VALUES = DEF_NUM_VALUES,
	parameter int MAX_WINDOW = DEF_MAX_WINDOW,
	localparam int IDX_W = $clog2(NUM_VALUES),
	localparam int CMD_W = 3 + 2 * IDX_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  swdc_cfg_t          cfg,
	input  swdc_stat_t         stat,
	input  logic               push,
	output logic               full,
	input  logic [VALUE_W-1:0] value,
	input  logic               last_item,
	output logic               cq_push,
	output logic [CMD_W-1:0]   cq_wdata,
	input  logic               cq_full
);

	localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
	localparam int RING_AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

	localparam logic F_RUN   = 1'b0;
	localparam logic F_DRAIN = 1'b1;

	typedef struct packed {
		logic             has_rem;
		logic             has_add;
		logic             report;
		logic [IDX_W-1:0] old_idx;
		logic [IDX_W-1:0] new_idx;
	} cmd_t;

	// Fold a value onto the table by restoring subtraction
	function automatic logic [IDX_W-1:0] to_index(input logic [VALUE_W-1:0] v);
		int r;
		r = int'(v);
		for (int i = VALUE_W - 1; i >= 0; i--) begin
			if (r >= (NUM_VALUES << i)) begin
				r = r - (NUM_VALUES << i);
			end
		end
		return IDX_W'(r);
	endfunction

	// Clamp the written size into one to the ring depth
	function automatic logic [FILL_W-1:0] clamp_window(input logic [WS_W-1:0] ws);
		logic [FILL_W-1:0] k;
		if (ws == '0) begin
			k = FILL_W'(1);
		end else if (32'(ws) > 32'(MAX_WINDOW)) begin
			k = FILL_W'(MAX_WINDOW);
		end else begin
			k = FILL_W'(ws);
		end
		return k;
	endfunction

	logic               fstate_q;
	logic [FILL_W-1:0]  k_q;
	logic [FILL_W-1:0]  fill_q;
	logic [RING_AW-1:0] pos_q;
	logic [FILL_W-1:0]  drain_n_q;
	logic [FILL_W-1:0]  drain_i_q;
	logic [IDX_W-1:0]   ring_q [MAX_WINDOW];
	logic [IDX_W-1:0]   ring_rd_q;

	logic               valid_s1;
	logic               rem_s1;
	logic               add_s1;
	logic               rep_s1;
	logic [IDX_W-1:0]   new_s1;

	logic               s1_free;
	logic               take;
	logic               accept;
	logic               issue_drain;
	logic               drain_last;
	logic [IDX_W-1:0]   new_idx;
	logic [FILL_W-1:0]  fill_inc;
	logic [FILL_W-1:0]  pos_inc;
	logic [RING_AW-1:0] slot;
	logic [FILL_W-1:0]  fill_n;
	logic [RING_AW-1:0] pos_n;
	logic               has_rem;
	logic               report;
	logic [RING_AW-1:0] ring_addr;
	cmd_t               cmd_out;

	// Handshake: stage one must be free or draining into the queue
	assign s1_free     = !valid_s1 || !cq_full;
	assign take        = (fstate_q == F_RUN) && !stat.clearing && s1_free;
	assign full        = !take;
	assign accept      = push && take;
	assign issue_drain = (fstate_q == F_DRAIN) && s1_free;
	assign drain_last  = (drain_i_q + 1'b1) == drain_n_q;
	assign new_idx     = to_index(value);
	assign fill_inc    = fill_q + 1'b1;
	assign pos_inc     = FILL_W'(pos_q) + 1'b1;

	// Classify: filling window or full window with eviction
	always_comb begin
		if (fill_q < k_q) begin
			slot    = fill_q[RING_AW-1:0];
			fill_n  = fill_inc;
			pos_n   = '0;
			has_rem = 1'b0;
			report  = (fill_inc == k_q);
		end else begin
			slot    = pos_q;
			fill_n  = fill_q;
			pos_n   = (pos_inc >= k_q) ? '0 : pos_inc[RING_AW-1:0];
			has_rem = 1'b1;
			report  = 1'b1;
		end
	end

	assign ring_addr = (fstate_q == F_DRAIN) ? drain_i_q[RING_AW-1:0] : slot;

	// Build the request towards the back part
	always_comb begin
		cmd_out.has_rem = rem_s1;
		cmd_out.has_add = add_s1;
		cmd_out.report  = rep_s1;
		cmd_out.old_idx = ring_rd_q;
		cmd_out.new_idx = new_s1;
	end

	assign cq_push  = valid_s1 && !cq_full;
	assign cq_wdata = CMD_W'(cmd_out);

	// Advance fill, position and the drain sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstate_q  <= F_RUN;
			k_q       <= FILL_W'(1);
			fill_q    <= '0;
			pos_q     <= '0;
			drain_n_q <= '0;
			drain_i_q <= '0;
			valid_s1  <= 1'b0;
		end else if (cfg.we) begin
			fstate_q  <= F_RUN;
			k_q       <= clamp_window(cfg.data);
			fill_q    <= '0;
			pos_q     <= '0;
			drain_n_q <= '0;
			drain_i_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= accept || issue_drain;
			end
			if (accept) begin
				if (last_item) begin
					fill_q    <= '0;
					pos_q     <= '0;
					drain_n_q <= fill_n;
					drain_i_q <= '0;
					fstate_q  <= F_DRAIN;
				end else begin
					fill_q <= fill_n;
					pos_q  <= pos_n;
				end
			end
			if (issue_drain) begin
				drain_i_q <= drain_i_q + 1'b1;
				if (drain_last) begin
					fstate_q <= F_RUN;
				end
			end
		end
	end

	// Hold stage-one payload; write the ring and read the evicted slot
	always_ff @(posedge clk) begin
		if (accept) begin
			rem_s1 <= has_rem;
			add_s1 <= 1'b1;
			rep_s1 <= report;
			new_s1 <= new_idx;
		end else if (issue_drain) begin
			rem_s1 <= 1'b1;
			add_s1 <= 1'b0;
			rep_s1 <= 1'b0;
			new_s1 <= '0;
		end
		if (accept) begin
			ring_q[ring_addr] <= new_idx;
		end
		if (accept || issue_drain) begin
			ring_rd_q <= ring_q[ring_addr];
		end
	end

endmodule

FILE: sv/swdc_back.sv
// Back part: occurrence table with one write and one read port, running
// distinct total, clearing sweep and result queue. Depends on swdc_pkg, swdc_fifo.
module swdc_back import swdc_pkg::*; #(
	parameter int NUM_VALUES = DEF_NUM_VALUES,
	localparam int IDX_W = $clog2(NUM_VALUES),
	localparam int CMD_W = 3 + 2 * IDX_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  swdc_cfg_t        cfg,
	output swdc_stat_t       stat,
	input  logic [CMD_W-1:0] cq_rdata,
	input  logic             cq_empty,
	output logic             cq_pop,
	output logic [CNT_W-1:0] distinct_count,
	output logic             empty,
	input  logic             pop
);

	typedef struct packed {
		logic             has_rem;
		logic             has_add;
		logic             report;
		logic [IDX_W-1:0] old_idx;
		logic [IDX_W-1:0] new_idx;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] addr;
		logic             inc;
		logic             report;
	} op_t;

	logic [CNT_W-1:0] tbl_q [NUM_VALUES];
	logic             clr_q;
	logic [IDX_W-1:0] clr_addr_q;
	logic             phase_q;
	logic [CNT_W-1:0] distinct_q;

	logic             op_v_s1;
	op_t              op_s1;
	logic [CNT_W-1:0] rd_s1;
	logic             byp_hit_s1;
	logic [CNT_W-1:0] byp_cnt_s1;

	cmd_t             head;
	op_t              op_nxt;
	logic             rem_phase;
	logic             last_op;
	logic             op_v;
	logic             op_take;
	logic             b_done;
	logic             b_free;
	logic [CNT_W-1:0] cnt_cur;
	logic [CNT_W-1:0] cnt_new;
	logic [CNT_W-1:0] distinct_n;
	logic             res_push;
	logic             res_full;
	logic             tbl_we;
	logic [IDX_W-1:0] tbl_wa;
	logic [CNT_W-1:0] tbl_wd;
	logic             clr_last;

	// Split a request into its eviction and its insertion
	assign head      = cmd_t'(cq_rdata);
	assign rem_phase = head.has_rem && !phase_q;
	assign last_op   = !rem_phase || !head.has_add;

	always_comb begin
		op_nxt.addr   = rem_phase ? head.old_idx : head.new_idx;
		op_nxt.inc    = !rem_phase;
		op_nxt.report = !rem_phase && head.report;
	end

	// Stage handshake: a reporting update waits for room in the result queue
	assign op_v    = !cq_empty && !clr_q;
	assign b_done  = op_v_s1 && !(op_s1.report && res_full);
	assign b_free  = !op_v_s1 || b_done;
	assign op_take = op_v && b_free;
	assign cq_pop  = op_take && last_op;

	// Update the count, forwarding the write of the previous update
	assign cnt_cur = byp_hit_s1 ? byp_cnt_s1 : rd_s1;

	always_comb begin
		if (op_s1.inc) begin
			cnt_new    = cnt_cur + 1'b1;
			distinct_n = (cnt_cur == '0) ? distinct_q + 1'b1 : distinct_q;
		end else begin
			cnt_new    = (cnt_cur != '0) ? cnt_cur - 1'b1 : '0;
			distinct_n = ((cnt_cur == CNT_W'(1)) && (distinct_q != '0)) ?
				distinct_q - 1'b1 : distinct_q;
		end
	end

	assign res_push = b_done && op_s1.report;

	// Table write port: clearing sweep or count write-back
	assign tbl_we   = clr_q || b_done;
	assign tbl_wa   = clr_q ? clr_addr_q : op_s1.addr;
	assign tbl_wd   = clr_q ? '0 : cnt_new;
	assign clr_last = (clr_addr_q == IDX_W'(NUM_VALUES - 1));

	assign stat.clearing = clr_q;

	// Sequence clearing, update stage and distinct total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			phase_q    <= 1'b0;
			distinct_q <= '0;
			op_v_s1    <= 1'b0;
			byp_hit_s1 <= 1'b0;
		end else if (cfg.we) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			phase_q    <= 1'b0;
			distinct_q <= '0;
			op_v_s1    <= 1'b0;
			byp_hit_s1 <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_last) begin
					clr_q <= 1'b0;
				end
			end
			if (b_free) begin
				op_v_s1 <= op_take;
			end
			if (b_done) begin
				distinct_q <= distinct_n;
			end
			if (op_take) begin
				phase_q    <= !last_op;
				byp_hit_s1 <= b_done && (op_s1.addr == op_nxt.addr);
			end
		end
	end

	// Hold the update payload and the forwarded count
	always_ff @(posedge clk) begin
		if (op_take) begin
			op_s1      <= op_nxt;
			byp_cnt_s1 <= cnt_new;
		end
	end

	// Occurrence table memory
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_q[tbl_wa] <= tbl_wd;
		end
		if (op_take) begin
			rd_s1 <= tbl_q[op_nxt.addr];
		end
	end

	// Results wait here for the receiver
	swdc_fifo #(
		.WIDTH (CNT_W),
		.DEPTH (RESQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (1'b0),
		.push   (res_push),
		.wdata  (distinct_n),
		.full   (res_full),
		.pop    (pop),
		.rdata  (distinct_count),
		.empty  (empty)
	);

endmodule

FILE: sv/sliding_window_distinct_count_top.sv
// Top level of the sliding-window distinct counter: front, request queue
// and back. Depends on swdc_pkg, swdc_fifo, swdc_front and swdc_back.
//
// Usage:
//   Values enter through push/full with value and last_item; a value is taken
//   on a clock edge with push high and full low. Once window_size values are
//   held, every value yields one distinct_count, read through empty/pop.
//   Values before the window fills yield nothing.
//   Throughput: one value a cycle while the window fills and no queue backs up;
//   once it is full, the table's single write port takes the eviction and the
//   insertion one after the other, while the front keeps taking values until
//   the request queue fills.
//   A value marked last_item starts a drain of the held window: full stays
//   high while one removal per held value is issued, then the next
//   sequence may start at once.
//   Reset, and every write of window_size (cfg_wr_en with cfg_wr_data),
//   starts a clearing sweep over all NUM_VALUES entries of the occurrence table;
//   full stays high meanwhile. window_size 0 acts as 1, above MAX_WINDOW as
//   MAX_WINDOW. Write it only while the block is idle.
//   When the receiver holds pop low, two results queue up, then the back part
//   stalls, the request queue fills and full rises.
module sliding_window_distinct_count_top import swdc_pkg::*; #(
	parameter int NUM_VALUES = DEF_NUM_VALUES,
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [WS_W-1:0]    cfg_wr_data,
	input  logic               push,
	output logic               full,
	input  logic [VALUE_W-1:0] value,
	input  logic               last_item,
	output logic               empty,
	input  logic               pop,
	output logic [CNT_W-1:0]   distinct_count
);

	localparam int IDX_W = $clog2(NUM_VALUES);
	localparam int CMD_W = 3 + 2 * IDX_W;

	swdc_cfg_t        cfg;
	swdc_stat_t       stat;
	logic             cq_push;
	logic [CMD_W-1:0] cq_wdata;
	logic             cq_full;
	logic             cq_pop;
	logic [CMD_W-1:0] cq_rdata;
	logic             cq_empty;

	// Bundle the configuration write
	assign cfg.we   = cfg_wr_en;
	assign cfg.data = cfg_wr_data;

	swdc_front #(
		.NUM_VALUES (NUM_VALUES),
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.stat      (stat),
		.push      (push),
		.full      (full),
		.value     (value),
		.last_item (last_item),
		.cq_push   (cq_push),
		.cq_wdata  (cq_wdata),
		.cq_full   (cq_full)
	);

	// Request queue between front and back; a restart drops its contents
	swdc_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (cfg_wr_en),
		.push   (cq_push),
		.wdata  (cq_wdata),
		.full   (cq_full),
		.pop    (cq_pop),
		.rdata  (cq_rdata),
		.empty  (cq_empty)
	);

	swdc_back #(
		.NUM_VALUES (NUM_VALUES)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.stat           (stat),
		.cq_rdata       (cq_rdata),
		.cq_empty       (cq_empty),
		.cq_pop         (cq_pop),
		.distinct_count (distinct_count),
		.empty          (empty),
		.pop            (pop)
	);

	// A window size write blocks input for the clearing sweep
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> full)
		else $error("input not blocked after window size write");

	// A fresh sweep starts with no pending requests
	a_sweep_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat.clearing) |-> cq_empty)
		else $error("requests left queued at start of clearing sweep");

	// The back part only takes requests that exist
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> !cq_empty)
		else $error("request queue popped while empty");

	// A distinct count never exceeds the window depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (32'(distinct_count) <= 32'(MAX_WINDOW)))
		else $error("distinct count above window depth");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for sliding_window_distinct_count_top: drives values through the
// push/full side, predicts every distinct count and checks each popped result in order.
// Depends on swdc_pkg and the RTL of the block only.
module tb import swdc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_VALUES    = DEF_NUM_VALUES;
	localparam int MAX_WINDOW    = DEF_MAX_WINDOW;
	localparam int IDLE_PCT      = 38;
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT   = 400000;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [WS_W-1:0]    cfg_wr_data = '0;
	logic               push        = 1'b0;
	logic               full;
	logic [VALUE_W-1:0] value       = '0;
	logic               last_item   = 1'b0;
	logic               empty;
	logic               pop         = 1'b0;
	logic [CNT_W-1:0]   distinct_count;

	// Predictor state: table, ring, fill and running count
	logic [CNT_W-1:0]   occ_table [NUM_VALUES];
	logic [VALUE_W-1:0] ring_vals [MAX_WINDOW];
	int unsigned        ring_oldest;
	int unsigned        held;
	logic [CNT_W-1:0]   distinct_now;
	logic [WS_W-1:0]    win_reg;

	logic [CNT_W-1:0]   expected_counts [$];
	logic [CNT_W-1:0]   want_count;

	int unsigned mismatches     = 0;
	int unsigned values_sent    = 0;
	int unsigned counts_checked = 0;
	int unsigned window_writes  = 0;
	int unsigned cycle_count    = 0;
	int unsigned hold_cycles    = 0;
	bit          steady_run     = 1'b0;

	sliding_window_distinct_count_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.push           (push),
		.full           (full),
		.value          (value),
		.last_item      (last_item),
		.empty          (empty),
		.pop            (pop),
		.distinct_count (distinct_count)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d counts outstanding", $time,
				cycle_count, expected_counts.size());
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void restart_tracking();
		for (int i = 0; i < NUM_VALUES; i++)
			occ_table[i] = '0;
		ring_oldest  = 0;
		held         = 0;
		distinct_now = '0;
	endfunction

	function automatic void drop_occurrence(input logic [VALUE_W-1:0] v);
		if (occ_table[v] != '0) begin
			occ_table[v] = occ_table[v] - 1'b1;
			if (occ_table[v] == '0 && distinct_now != '0)
				distinct_now = distinct_now - 1'b1;
		end
	endfunction

	function automatic void note_occurrence(input logic [VALUE_W-1:0] v);
		if (occ_table[v] == '0)
			distinct_now = distinct_now + 1'b1;
		occ_table[v] = occ_table[v] + 1'b1;
	endfunction

	// Advance the window by one accepted request and queue the count it yields
	function automatic void track_window(input logic [VALUE_W-1:0] v, input logic last);
		int unsigned k;
		int unsigned slot;
		k = win_reg;
		if (k == 0)
			k = 1;
		if (k > MAX_WINDOW)
			k = MAX_WINDOW;
		if (held < k) begin
			ring_vals[held % MAX_WINDOW] = v;
			note_occurrence(v);
			held++;
			if (held == k) begin
				ring_oldest = 0;
				expected_counts.push_back(distinct_now);
			end
		end else begin
			slot = ring_oldest % MAX_WINDOW;
			drop_occurrence(ring_vals[slot]);
			ring_vals[slot] = v;
			note_occurrence(v);
			ring_oldest = slot + 1;
			if (ring_oldest >= k)
				ring_oldest = 0;
			expected_counts.push_back(distinct_now);
		end
		// Drain the held window on the end of a sequence
		if (last) begin
			for (int unsigned i = 0; i < held && i < MAX_WINDOW; i++)
				drop_occurrence(ring_vals[i]);
			held         = 0;
			ring_oldest  = 0;
			distinct_now = '0;
		end
	endfunction

	// ---------------------------------------------------------------- result side

	// Pop with random gaps, or hold off for a counted stretch when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				pop <= 1'b0;
				hold_cycles--;
			end else begin
				pop <= steady_run || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Compare each popped count with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_counts.size() == 0) begin
				$display("%0t: unexpected distinct_count: expected none, actual %0d",
					$time, distinct_count);
				mismatches++;
			end else begin
				want_count = expected_counts.pop_front();
				counts_checked++;
				if (distinct_count !== want_count) begin
					$display("%0t: distinct_count mismatch: expected %0d, actual %0d",
						$time, want_count, distinct_count);
					mismatches++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- request side

	// Offer one value until the block takes it; called and left at a falling edge
	task automatic send_value(input logic [VALUE_W-1:0] v, input logic last);
		while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push      <= 1'b1;
		value     <= v;
		last_item <= last;
		do
			@(posedge clk);
		while (full);
		track_window(v, last);
		values_sent++;
		@(negedge clk);
	endtask

	// Send a sequence drawn from a small run of values, or from the full range
	task automatic send_sequence(input int unsigned len, input int unsigned alphabet,
		input bit terminate);
		logic [VALUE_W-1:0] base;
		logic [VALUE_W-1:0] v;
		base = VALUE_W'($urandom);
		for (int unsigned n = 0; n < len; n++) begin
			if (alphabet == 0)
				v = VALUE_W'($urandom);
			else
				v = base + VALUE_W'($urandom_range(alphabet - 1));
			send_value(v, terminate && (n == len - 1));
		end
	endtask

	// Hold the input until every count has come and any drain has finished
	task automatic wait_idle();
		push <= 1'b0;
		while (expected_counts.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write window_size; the block restarts its sequence
	task automatic write_window(input logic [WS_W-1:0] ws);
		cfg_wr_data <= ws;
		cfg_wr_en   <= 1'b1;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		win_reg = ws;
		restart_tracking();
		window_writes++;
	endtask

	// ---------------------------------------------------------------- tests

	// Window of one after reset: every value is its own window
	task automatic test_default_window();
		send_value(10'd0, 1'b0);
		send_value(10'h3FF, 1'b0);
		send_value(10'h3FF, 1'b0);
		send_value(10'h155, 1'b0);
		send_value(10'h2AA, 1'b1);
		wait_idle();
	endtask

	// A sequence shorter than the window, then one that ends a full window
	task automatic test_short_sequence();
		write_window(9'd4);
		send_value(10'd3, 1'b0);
		send_value(10'd3, 1'b0);
		send_value(10'd8, 1'b1);
		send_value(10'd7, 1'b0);
		send_value(10'd7, 1'b0);
		send_value(10'd9, 1'b0);
		send_value(10'd7, 1'b0);
		send_value(10'd12, 1'b1);
		wait_idle();
	endtask

	// Window size zero behaves as one
	task automatic test_window_zero();
		write_window(9'd0);
		send_value(10'd5, 1'b0);
		send_value(10'd5, 1'b0);
		send_value(10'd6, 1'b1);
		wait_idle();
	endtask

	// Random small windows with mostly well-formed sequences; one left open
	task automatic test_random_windows();
		int unsigned ws;
		int unsigned len;
		int unsigned alph;
		for (int round = 0; round < 8; round++) begin
			ws = $urandom_range(2, 16);
			write_window(WS_W'(ws));
			steady_run = (round == 3);
			for (int s = 0; s < 4; s++) begin
				if ($urandom_range(9) == 0)
					len = $urandom_range(1, ws);
				else
					len = $urandom_range(ws, 2 * ws + 4);
				alph = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, ws + 2);
				send_sequence(len, alph, !(round == 5 && s == 3));
			end
			steady_run = 1'b0;
			wait_idle();
		end
	endtask

	// Receiver stalls while the sender keeps offering, so full must rise
	task automatic test_backpressure();
		write_window(9'd3);
		// Wait out the clearing sweep so the stall meets live traffic
		while (full)
			@(negedge clk);
		hold_cycles = 150;
		send_sequence(40, 5, 1'b1);
		wait_idle();
	endtask

	// Largest window, and a size above the limit that clamps to it
	task automatic test_large_windows();
		write_window(WS_W'(MAX_WINDOW));
		send_sequence(300, 40, 1'b1);
		wait_idle();
		write_window(9'd511);
		send_sequence(270, 300, 1'b1);
		wait_idle();
	endtask

	initial begin
		win_reg = 9'd1;
		restart_tracking();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_window();
		test_short_sequence();
		test_window_zero();
		test_random_windows();
		test_backpressure();
		test_large_windows();

		wait_idle();
		$display("%0d values sent across %0d window_size writes, %0d distinct counts checked",
			values_sent, window_writes, counts_checked);
		$display("windows covered: 0, 1, 2..16 random, 256 and 511 with drains and stalls");
		if (mismatches == 0 && expected_counts.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

FILE: sliding_window_distinct_count_top.f
sv/swdc_pkg.sv
sv/swdc_fifo.sv
sv/swdc_front.sv
sv/swdc_back.sv
sv/sliding_window_distinct_count_top.sv
verif/tb.sv
